// ----- src/bpc_pkg.sv -----
// Package for the barometric compensation block: types, constants and
// small arithmetic helpers. No dependencies.
package bpc_pkg;

    localparam int unsigned DivBits = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] RegCalA = 2'd0;
    localparam logic [1:0] RegCalB = 2'd1;
    localparam logic [1:0] RegCalC = 2'd2;
    localparam logic [1:0] RegOss  = 2'd3;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic [15:0] ut;
        logic [23:0] up;
    } t_item;

    // Unsigned truncating division stage of a radix-2 restoring divider.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
    } t_div;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul32 = p[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
        asr = 32'($signed(v) >>> s);
    endfunction

    // One step of restoring division.
    function automatic t_div div_step(input t_div d);
        logic [32:0] trial;
        t_div o;
        trial = {d.rem[31:0], d.quo[31]} - {1'b0, d.den};
        o.den = d.den;
        if (!trial[32]) begin
            o.rem = trial[31:0];
            o.quo = {d.quo[30:0], 1'b1};
        end else begin
            o.rem = {d.rem[30:0], d.quo[31]};
            o.quo = {d.quo[30:0], 1'b0};
        end
        div_step = o;
    endfunction

endpackage

// ----- src/bpc_front.sv -----
// Front part: accepts transactions into a two-entry queue.
// Depends on bpc_pkg.
module bpc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bpc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output bpc_pkg::t_item o_item
);
    import bpc_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ----- src/bpc_back.sv -----
// Back part: pipelined compensation arithmetic with two 32-stage dividers.
// Depends on bpc_pkg.
module bpc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bpc_pkg::t_item i_item,
    input  logic [63:0]    i_cal_a,
    input  logic [63:0]    i_cal_b,
    input  logic [31:0]    i_cal_c,
    input  logic [1:0]     i_oss,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_temp,
    output logic [31:0]    o_pres,
    output logic           o_err
);
    import bpc_pkg::*;

    // Pipeline context carried alongside the dividers.
    typedef struct packed {
        logic        vld;
        logic        err;
        logic        neg;
        logic [31:0] a;
        logic [31:0] b;
        logic [23:0] up;
    } t_ctx;

    localparam int unsigned D = DivBits;

    logic        w_en;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign ac1 = sext16(i_cal_a[15:0]);
    assign ac2 = sext16(i_cal_a[31:16]);
    assign ac3 = sext16(i_cal_a[47:32]);
    assign ac4 = {16'd0, i_cal_a[63:48]};
    assign ac5 = {16'd0, i_cal_b[15:0]};
    assign ac6 = {16'd0, i_cal_b[31:16]};
    assign b1  = sext16(i_cal_b[47:32]);
    assign b2  = sext16(i_cal_b[63:48]);
    assign mc  = sext16(i_cal_c[15:0]);
    assign md  = sext16(i_cal_c[31:16]);

    // Output register with a one-deep skid.
    logic        r_ov;
    logic [15:0] r_ot;
    logic [31:0] r_op;
    logic        r_oe;
    logic        r_sv;
    logic [15:0] r_st;
    logic [31:0] r_sp;
    logic        r_se;
    assign w_en    = !r_sv;
    assign o_ready = w_en;

    // Stage 1: X1.
    t_ctx r_s1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1.vld <= 1'b0;
        else if (w_en) begin
            r_s1.vld <= i_valid;
            r_s1.a   <= asr(mul32({16'd0, i_item.ut} - ac6, ac5), 15);
            r_s1.up  <= i_item.up;
            r_s1.err <= 1'b0;
            r_s1.neg <= 1'b0;
            r_s1.b   <= 32'd0;
        end
    end

    // Stage 2: set up signed division mc*2048 / (X1+md).
    t_ctx r_s2;
    t_div r_d1 [D+1];
    logic [31:0] w_dd, w_nn;
    assign w_dd = r_s1.a + md;
    assign w_nn = mul32(mc, 32'd2048);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2.vld <= 1'b0;
        else if (w_en) begin
            r_s2     <= r_s1;
            r_s2.err <= (w_dd == 32'd0);
            r_s2.neg <= w_nn[31] ^ w_dd[31];
            r_d1[0].rem <= 32'd0;
            r_d1[0].quo <= w_nn[31] ? 32'd0 - w_nn : w_nn;
            r_d1[0].den <= w_dd[31] ? 32'd0 - w_dd : w_dd;
        end
    end

    // Divider 1 pipeline, one bit per stage.
    t_ctx r_c1 [D+1];
    always_comb r_c1[0] = r_s2;
    for (genvar g = 0; g < D; g++) begin : g_d1
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_c1[g+1].vld <= 1'b0;
            else if (w_en) begin
                r_c1[g+1] <= r_c1[g];
                r_d1[g+1] <= div_step(r_d1[g]);
            end
        end
    end

    // Stage 3: B5, temperature, B6.
    t_ctx r_s3;
    logic [31:0] w_x2, w_b5, w_t;
    logic [15:0] r_temp;
    assign w_x2 = r_c1[D].neg ? 32'd0 - r_d1[D].quo : r_d1[D].quo;
    assign w_b5 = r_c1[D].a + w_x2;
    assign w_t  = asr(w_b5 + 32'd8, 4);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3.vld <= 1'b0;
        else if (w_en) begin
            r_s3   <= r_c1[D];
            r_s3.a <= w_b5 - 32'd4000;
            if ($signed(w_t) > 32'sd32767) r_temp <= 16'h7fff;
            else if ($signed(w_t) < -32'sd32768) r_temp <= 16'h8000;
            else r_temp <= w_t[15:0];
        end
    end

    // Stage 4: square term and coefficient products with B6.
    t_ctx r_s4;
    logic [15:0] r_temp4;
    logic [31:0] r_p2, r_p3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4.vld <= 1'b0;
        else if (w_en) begin
            r_s4    <= r_s3;
            r_s4.b  <= asr(mul32(r_s3.a, r_s3.a), 12);
            r_p2    <= asr(mul32(ac2, r_s3.a), 11);
            r_p3    <= asr(mul32(ac3, r_s3.a), 13);
            r_temp4 <= r_temp;
        end
    end

    // Stage 5: products with the square term.
    t_ctx r_s5;
    logic [15:0] r_temp5;
    logic [31:0] r_q1, r_q2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5.vld <= 1'b0;
        else if (w_en) begin
            r_s5    <= r_s4;
            r_q1    <= asr(mul32(b2, r_s4.b), 11) + r_p2;
            r_q2    <= r_p3 + asr(mul32(b1, r_s4.b), 16) + 32'd2;
            r_temp5 <= r_temp4;
        end
    end

    // Stage 6: B3 and B4.
    t_ctx r_s6;
    logic [15:0] r_temp6;
    logic [31:0] w_b3s, w_b3;
    assign w_b3s = ((mul32(ac1, 32'd4) + r_q1) << i_oss) + 32'd2;
    assign w_b3  = w_b3s[31] ? 32'd0 - ((32'd0 - w_b3s) >> 2) : (w_b3s >> 2);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s6.vld <= 1'b0;
        else if (w_en) begin
            r_s6    <= r_s5;
            r_s6.a  <= w_b3;
            r_s6.b  <= mul32(ac4, asr(r_q2, 2) + 32'd32768) >> 15;
            r_temp6 <= r_temp5;
        end
    end

    // Stage 7: B7 and division set-up.
    t_ctx r_s7;
    logic [15:0] r_temp7;
    logic [31:0] w_b7;
    t_div r_d2 [D+1];
    assign w_b7 = mul32({8'd0, r_s6.up} - r_s6.a, 32'd50000 >> i_oss);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s7.vld <= 1'b0;
        else if (w_en) begin
            r_s7     <= r_s6;
            r_s7.err <= r_s6.err || (r_s6.b == 32'd0);
            r_s7.neg <= w_b7[31];
            r_d2[0].rem <= 32'd0;
            r_d2[0].quo <= w_b7[31] ? w_b7 : {w_b7[30:0], 1'b0};
            r_d2[0].den <= r_s6.b;
            r_temp7  <= r_temp6;
        end
    end

    // Divider 2 pipeline.
    t_ctx r_c2 [D+1];
    logic [15:0] r_tp [D+1];
    always_comb r_c2[0] = r_s7;
    always_comb r_tp[0] = r_temp7;
    for (genvar g = 0; g < D; g++) begin : g_d2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_c2[g+1].vld <= 1'b0;
            else if (w_en) begin
                r_c2[g+1] <= r_c2[g];
                r_d2[g+1] <= div_step(r_d2[g]);
                r_tp[g+1] <= r_tp[g];
            end
        end
    end

    // Stage 8: pressure, and its squared correction term.
    t_ctx r_s8;
    logic [15:0] r_temp8;
    logic [31:0] w_p, w_t8;
    assign w_p  = r_c2[D].neg ? {r_d2[D].quo[30:0], 1'b0} : r_d2[D].quo;
    assign w_t8 = asr(w_p, 8);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s8.vld <= 1'b0;
        else if (w_en) begin
            r_s8    <= r_c2[D];
            r_s8.a  <= w_p;
            r_s8.b  <= mul32(w_t8, w_t8);
            r_temp8 <= r_tp[D];
        end
    end

    // Stage 9: correction products.
    t_ctx r_s9;
    logic [15:0] r_temp9;
    logic [31:0] r_x1, r_x2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s9.vld <= 1'b0;
        else if (w_en) begin
            r_s9    <= r_s8;
            r_x1    <= asr(mul32(r_s8.b, 32'd3038), 16);
            r_x2    <= asr(mul32(32'd0 - 32'd7357, r_s8.a), 16);
            r_temp9 <= r_temp8;
        end
    end

    // Final result and output register with skid.
    logic [31:0] w_pf;
    logic        w_take;
    assign w_pf   = r_s9.a + asr(r_x1 + r_x2 + 32'd3791, 4);
    assign w_take = w_en && r_s9.vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || i_ready) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_ot <= r_st;
                    r_op <= r_sp;
                    r_oe <= r_se;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= w_take;
                    r_ot <= r_s9.err ? 16'd0 : r_temp9;
                    r_op <= r_s9.err ? 32'd0 : w_pf;
                    r_oe <= r_s9.err;
                end
            end else if (w_take) begin
                r_sv <= 1'b1;
                r_st <= r_s9.err ? 16'd0 : r_temp9;
                r_sp <= r_s9.err ? 32'd0 : w_pf;
                r_se <= r_s9.err;
            end
        end
    end
    assign o_valid = r_ov;
    assign o_temp  = r_ot;
    assign o_pres  = r_op;
    assign o_err   = r_oe;
endmodule

// ----- src/barometric_pressure_compensation_top.sv -----
// Top level of the barometric compensation block: APB registers, the
// input queue and the compensation pipeline. Depends on bpc_pkg, bpc_front, bpc_back.
// The block accepts one transaction per cycle while the input queue has room,
// and each accepted transaction passes through the input queue, two set-up
// stages, the two 32-stage bit-per-stage division pipelines, seven arithmetic
// stages around them and the output register. The pipeline stalls as a whole
// only while both the output register and its skid entry are full.
module barometric_pressure_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_raw_temperature,
    input  logic [23:0] i_raw_pressure,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_temperature_tenths,
    output logic signed [31:0] o_pressure_pa,
    output logic        o_divide_error
);
    import bpc_pkg::*;

    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    logic        w_wr;
    logic [1:0]  w_idx;
    t_item       w_in, w_q;
    logic        w_qv, w_qr;
    logic [15:0] w_t;
    logic [31:0] w_p;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2:0] == 3'd0);
    assign w_idx  = paddr[4:3];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= 64'd0;
            r_cal_b <= 64'd0;
            r_cal_c <= 32'd0;
            r_oss   <= 2'd3;
        end else if (w_wr) begin
            case (w_idx)
                RegCalA: r_cal_a <= pwdata;
                RegCalB: r_cal_b <= pwdata;
                RegCalC: r_cal_c <= pwdata[31:0];
                RegOss:  r_oss   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_idx)
            RegCalA: prdata = r_cal_a;
            RegCalB: prdata = r_cal_b;
            RegCalC: prdata = {32'd0, r_cal_c};
            RegOss:  prdata = {62'd0, r_oss};
            default: prdata = 64'd0;
        endcase
    end

    assign w_in.ut = i_raw_temperature;
    assign w_in.up = i_raw_pressure;

    bpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    bpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_item(w_q), .i_cal_a(r_cal_a), .i_cal_b(r_cal_b), .i_cal_c(r_cal_c),
        .i_oss(r_oss), .o_valid(o_valid), .i_ready(i_ready), .o_temp(w_t),
        .o_pres(w_p), .o_err(o_divide_error)
    );

    assign o_temperature_tenths = w_t;
    assign o_pressure_pa        = w_p;
endmodule
